// ===== rtl/wbss_pkg.sv =====
// Shared constants and types for the wildcard byte signature scan unit.
package wbss_pkg;

    localparam int MAX_SIG_BYTES = 32;
    localparam int ADDR_BITS     = 48;
    localparam int LEN_BITS      = 6;
    localparam int OFFSET_BITS   = 32;
    localparam int DATA_BITS     = 64;
    localparam int PADDR_BITS    = 6;
    localparam int REG_IDX_LSB   = 3;

    localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

    typedef logic [MAX_SIG_BYTES-1:0][7:0] byte_vec_t;

    typedef enum logic [2:0] {
        REG_SIG_0_7    = 3'd0,
        REG_SIG_8_15   = 3'd1,
        REG_SIG_16_23  = 3'd2,
        REG_SIG_24_31  = 3'd3,
        REG_SIG_LENGTH = 3'd4,
        REG_BASE_ADDR  = 3'd5,
        REG_OFFSET     = 3'd6
    } reg_idx_t;

    // Signature prepared for the window compare: entry k lines up with the
    // byte received k requests ago.
    typedef struct packed {
        byte_vec_t              sig_aligned;
        logic [MAX_SIG_BYTES-1:0] care;
        logic [LEN_BITS-1:0]    len_eff;
        logic [ADDR_BITS-1:0]   addr_bias;
    } cfg_t;

endpackage

// ===== rtl/wbss_cfg_regs.sv =====
// Configuration registers and the signature alignment derived from them.
module wbss_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wbss_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [wbss_pkg::DATA_BITS-1:0]       pwdata,
    output logic [wbss_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready,
    output wbss_pkg::cfg_t                       cfg
);

    logic [3:0][wbss_pkg::DATA_BITS-1:0]   sig_reg;
    logic [wbss_pkg::LEN_BITS-1:0]         len_reg;
    logic [wbss_pkg::ADDR_BITS-1:0]        base_reg;
    logic [wbss_pkg::OFFSET_BITS-1:0]      offset_reg;
    wbss_pkg::byte_vec_t                   sig_bytes;
    wbss_pkg::cfg_t                        cfg_reg;
    wbss_pkg::cfg_t                        cfg_next;
    wbss_pkg::reg_idx_t                    reg_idx;
    logic                                  wr_en;

    assign pready    = 1'b1;
    assign reg_idx   = wbss_pkg::reg_idx_t'(paddr[wbss_pkg::PADDR_BITS-1:wbss_pkg::REG_IDX_LSB]);
    assign wr_en     = psel && penable && pwrite;
    assign sig_bytes = sig_reg;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg    <= '0;
            len_reg    <= wbss_pkg::LEN_BITS'(1);
            base_reg   <= '0;
            offset_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                wbss_pkg::REG_SIG_0_7:    sig_reg[0] <= pwdata;
                wbss_pkg::REG_SIG_8_15:   sig_reg[1] <= pwdata;
                wbss_pkg::REG_SIG_16_23:  sig_reg[2] <= pwdata;
                wbss_pkg::REG_SIG_24_31:  sig_reg[3] <= pwdata;
                wbss_pkg::REG_SIG_LENGTH: len_reg    <= pwdata[wbss_pkg::LEN_BITS-1:0];
                wbss_pkg::REG_BASE_ADDR:  base_reg   <= pwdata[wbss_pkg::ADDR_BITS-1:0];
                wbss_pkg::REG_OFFSET:     offset_reg <= pwdata[wbss_pkg::OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wbss_pkg::REG_SIG_0_7:    prdata = sig_reg[0];
            wbss_pkg::REG_SIG_8_15:   prdata = sig_reg[1];
            wbss_pkg::REG_SIG_16_23:  prdata = sig_reg[2];
            wbss_pkg::REG_SIG_24_31:  prdata = sig_reg[3];
            wbss_pkg::REG_SIG_LENGTH: prdata = wbss_pkg::DATA_BITS'(len_reg);
            wbss_pkg::REG_BASE_ADDR:  prdata = wbss_pkg::DATA_BITS'(base_reg);
            wbss_pkg::REG_OFFSET:     prdata = wbss_pkg::DATA_BITS'(offset_reg);
            default:                  prdata = '0;
        endcase
    end

    // The compare sees signature byte L-1-k against the byte received k requests ago.
    always_comb
    begin
        logic [wbss_pkg::LEN_BITS-1:0] sel;
        logic [7:0]                    sb;
        if (len_reg == '0)
            cfg_next.len_eff = wbss_pkg::LEN_BITS'(1);
        else if (len_reg > wbss_pkg::LEN_BITS'(wbss_pkg::MAX_SIG_BYTES))
            cfg_next.len_eff = wbss_pkg::LEN_BITS'(wbss_pkg::MAX_SIG_BYTES);
        else
            cfg_next.len_eff = len_reg;
        for (int k = 0; k < wbss_pkg::MAX_SIG_BYTES; k++)
        begin
            sel = cfg_next.len_eff - wbss_pkg::LEN_BITS'(k + 1);
            sb  = sig_bytes[sel[wbss_pkg::LEN_BITS-2:0]];
            cfg_next.sig_aligned[k] = sb;
            cfg_next.care[k] = (wbss_pkg::LEN_BITS'(k) < cfg_next.len_eff)
                               && (sb != wbss_pkg::WILDCARD_BYTE);
        end
        cfg_next.addr_bias = base_reg
                             - wbss_pkg::ADDR_BITS'(cfg_next.len_eff)
                             + wbss_pkg::ADDR_BITS'(offset_reg);
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

endmodule

// ===== rtl/wildcard_byte_signature_scan_unit.sv =====
// Top level of the wildcard byte signature scan unit: byte window, compare and result register.
//
//  Channel   Direction  Handshake            Payload
//  in        request    in_valid / in_stall  mem_byte, region_end
//  out       result     out_valid/out_stall  found, match_address
//  cfg       APB r/w    psel/penable/pready  paddr, pwdata, prdata
//
// One byte is accepted per cycle while in_stall is low; its result follows the window stage.
// The window register feeds 32 parallel byte compares straight into the result register.
// Reset clears the byte count, the match flag and both valid flags.
// A stalled result holds the result register; one further byte may then wait in the
// window stage, after which in_stall rises.
module wildcard_byte_signature_scan_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       mem_byte,
    input  logic                             region_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [wbss_pkg::ADDR_BITS-1:0]   match_address,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbss_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [wbss_pkg::DATA_BITS-1:0]   pwdata,
    output logic [wbss_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);

    wbss_pkg::cfg_t                   cfg;
    wbss_pkg::byte_vec_t              window_reg;
    logic [wbss_pkg::ADDR_BITS-1:0]   count_reg;
    logic [wbss_pkg::ADDR_BITS-1:0]   count_base;
    logic                             s1_valid_reg;
    logic                             s1_last_reg;
    logic                             match_reported_reg;
    logic                             match_reported_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             found_reg;
    logic                             found_next;
    logic [wbss_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [wbss_pkg::ADDR_BITS-1:0]   addr_next;
    logic                             out_free;
    logic                             accept;
    logic                             process;
    logic                             window_full;
    logic                             pattern_ok;
    logic                             hit;

    wbss_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign process  = s1_valid_reg && out_free;

    // A new region starts from an empty count after the last byte of the previous one.
    assign count_base = s1_last_reg ? '0 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= region_end;
                count_reg    <= count_base + wbss_pkg::ADDR_BITS'(1);
            end
            else if (process)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= {window_reg[wbss_pkg::MAX_SIG_BYTES-2:0], mem_byte};
        end
    end

    always_comb
    begin
        pattern_ok = 1'b1;
        for (int k = 0; k < wbss_pkg::MAX_SIG_BYTES; k++)
        begin
            if (cfg.care[k] && (cfg.sig_aligned[k] != window_reg[k]))
                pattern_ok = 1'b0;
        end
    end

    assign window_full = count_reg >= wbss_pkg::ADDR_BITS'(cfg.len_eff);
    assign hit         = !match_reported_reg && window_full && pattern_ok;

    always_comb
    begin
        match_reported_next = match_reported_reg;
        out_valid_next      = out_valid_reg;
        found_next          = found_reg;
        addr_next           = addr_reg;
        if (process)
        begin
            out_valid_next      = hit || (s1_last_reg && !match_reported_reg);
            found_next          = hit;
            addr_next           = hit ? (cfg.addr_bias + count_reg) : '0;
            match_reported_next = s1_last_reg ? 1'b0 : (match_reported_reg || hit);
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reported_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            match_reported_reg <= match_reported_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

`ifndef SYNTH
    a_not_found_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (addr_reg == '0))
        else $error("Not-found result carries a non-zero address.");

    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("Input stalled without a pending byte and a held result.");

    a_match_flag_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_reported_reg) |-> (out_valid_reg && found_reg))
        else $error("Match flag set without a found result.");

    a_one_result_per_region: assert property (@(posedge clk) disable iff (!rst_n)
        (process && match_reported_reg) |=> !(out_valid_reg && found_reg && $rose(out_valid_reg)))
        else $error("Second found result within one region.");
`endif

endmodule
